@@ rtl/ctc_pkg.sv @@
// Shared types and constants of the caterpillar tree checker.
package ctc_pkg;

  // Default graph capacity and fixed field widths
  localparam int unsigned MaxNodesDef = 128;
  localparam int unsigned ActW        = 2;
  localparam int unsigned NodeW       = 8;
  localparam int unsigned GnumW       = 16;
  localparam int unsigned QueueDepth  = 4;

  // Saturating two-bit counters: degree saturates at two, neighbour count at three
  localparam logic [1:0] CntZero = 2'd0;
  localparam logic [1:0] CntOne  = 2'd1;
  localparam logic [1:0] CntTwo  = 2'd2;
  localparam logic [1:0] CntMore = 2'd3;

  typedef enum logic [ActW-1:0] {
    ACT_START  = 2'd0,
    ACT_EDGE   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_EDGE,
    CMD_FAIL,
    CMD_FINISH
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e          op;
    logic [GnumW-1:0] gnum;
  } cmd_hdr_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_FU,
    S_FV,
    S_DU,
    S_DV,
    S_PRD,
    S_PDU,
    S_PDV,
    S_PCHK,
    S_PIU,
    S_PIV,
    S_EMIT
  } back_state_e;

endpackage

@@ rtl/ctc_if.sv @@
// Valid/ready channel interfaces for items and results.
interface ctc_in_if;
  import ctc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ActW-1:0]  action;
  logic [NodeW-1:0] node_count;
  logic [NodeW-1:0] first_node;
  logic [NodeW-1:0] second_node;
  modport source (output valid, action, node_count, first_node, second_node, input ready);
  modport sink   (input valid, action, node_count, first_node, second_node, output ready);
endinterface

interface ctc_out_if;
  import ctc_pkg::*;
  logic             valid;
  logic             ready;
  logic             is_caterpillar;
  logic [GnumW-1:0] graph_number;
  modport source (output valid, is_caterpillar, graph_number, input ready);
  modport sink   (input valid, is_caterpillar, graph_number, output ready);
endinterface

@@ rtl/ctc_front.sv @@
// Front end: accepts items, range-checks edges and issues commands.
module ctc_front #(
  parameter int unsigned MAX_NODES = ctc_pkg::MaxNodesDef,
  parameter int unsigned NW = $clog2(MAX_NODES + 1),
  parameter int unsigned IW = $clog2(MAX_NODES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ctc_in_if.sink           item_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output ctc_pkg::cmd_hdr_t hdr_o,
  output logic [NW-1:0]    arg_a_o,
  output logic [IW-1:0]    arg_b_o
);
  import ctc_pkg::*;

  localparam int unsigned CW = (NW > NodeW) ? NW : NodeW;

  logic [NW-1:0]    niu_q, niu_d;
  logic [GnumW-1:0] gcnt_q, gcnt_d;
  logic [CW-1:0]    n_ext, a_ext, b_ext, niu_ext;
  logic [NW-1:0]    n_clamp;
  logic             in_range, fire;
  act_e             act;

  assign act     = act_e'(item_i.action);
  assign n_ext   = CW'(item_i.node_count);
  assign a_ext   = CW'(item_i.first_node);
  assign b_ext   = CW'(item_i.second_node);
  assign niu_ext = CW'(niu_q);
  assign n_clamp = (n_ext > CW'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(n_ext);
  assign in_range = (a_ext != '0) && (b_ext != '0) && (a_ext <= niu_ext) && (b_ext <= niu_ext);

  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid && (act != ACT_NONE);
  assign fire         = item_i.valid && item_i.ready;

  // Classify the item into a command
  always_comb begin
    hdr_o.op   = CMD_FAIL;
    hdr_o.gnum = gcnt_q;
    arg_a_o    = NW'(a_ext - CW'(1));
    arg_b_o    = IW'(b_ext - CW'(1));
    case (act)
      ACT_START: begin
        hdr_o.op = CMD_START;
        arg_a_o  = n_clamp;
      end
      ACT_EDGE:   hdr_o.op = in_range ? CMD_EDGE : CMD_FAIL;
      ACT_FINISH: hdr_o.op = CMD_FINISH;
      default:    hdr_o.op = CMD_FAIL;
    endcase
  end

  // Track node count and graph number at acceptance
  always_comb begin
    niu_d  = niu_q;
    gcnt_d = gcnt_q;
    if (fire && act == ACT_START) begin
      niu_d  = n_clamp;
      gcnt_d = gcnt_q + GnumW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      niu_q  <= '0;
      gcnt_q <= '0;
    end else begin
      niu_q  <= niu_d;
      gcnt_q <= gcnt_d;
    end
  end

endmodule

@@ rtl/ctc_fifo.sv @@
// Short command queue between front and back end.
module ctc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ctc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Store beat at the write pointer
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ rtl/ctc_back.sv @@
// Back end: union-find, degree tracking, caterpillar check and result register.
module ctc_back #(
  parameter int unsigned MAX_NODES = ctc_pkg::MaxNodesDef,
  parameter int unsigned NW = $clog2(MAX_NODES + 1),
  parameter int unsigned IW = $clog2(MAX_NODES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  ctc_pkg::cmd_hdr_t hdr_i,
  input  logic [NW-1:0]     arg_a_i,
  input  logic [IW-1:0]     arg_b_i,
  ctc_out_if.source         result_o
);
  import ctc_pkg::*;

  back_state_e state_q, state_d;

  logic [IW-1:0]    cur_q, cur_d, ru_q, ru_d, cu_q, cu_d, cv_q, cv_d;
  logic [NW-1:0]    idx_q, idx_d, niu_q, niu_d, comp_q, comp_d, ecnt_q, ecnt_d;
  logic [GnumW-1:0] gnum_q, gnum_d;
  logic             valid_q, valid_d, judged_q, judged_d, verdict_q, verdict_d;
  logic             res_q, res_d, dbig_q, dbig_d;
  logic             out_valid_q, out_valid_d, out_res_q;
  logic [GnumW-1:0] out_gnum_q;
  logic             slot_free, load, last_edge, last_clr;
  logic [NW-1:0]    idx_inc;

  // Parent, degree, neighbour-count and edge-list memories
  logic [IW-1:0]   par_mem [MAX_NODES];
  logic [IW-1:0]   par_wa, par_wd, par_ra, par_rd_q;
  logic            par_we;
  logic [1:0]      deg_mem [MAX_NODES];
  logic [IW-1:0]   deg_wa, deg_ra;
  logic [1:0]      deg_wd, deg_rd_q;
  logic            deg_we;
  logic [1:0]      inn_mem [MAX_NODES];
  logic [IW-1:0]   inn_wa, inn_ra;
  logic [1:0]      inn_wd, inn_rd_q;
  logic            inn_we;
  logic [2*IW-1:0] edg_mem [MAX_NODES];
  logic [IW-1:0]   edg_wa, edg_ra;
  logic [2*IW-1:0] edg_wd, edg_rd_q;
  logic            edg_we, edg_re;
  logic [IW-1:0]   eu, ev;

  assign eu        = edg_rd_q[2*IW-1:IW];
  assign ev        = edg_rd_q[IW-1:0];
  assign slot_free = !out_valid_q || result_o.ready;
  assign idx_inc   = idx_q + NW'(1);
  assign last_edge = (idx_inc == ecnt_q);
  assign last_clr  = (idx_inc == niu_q);

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd_q <= par_mem[par_ra];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd_q <= deg_mem[deg_ra];
    if (inn_we) inn_mem[inn_wa] <= inn_wd;
    inn_rd_q <= inn_mem[inn_ra];
    if (edg_we) edg_mem[edg_wa] <= edg_wd;
    if (edg_re) edg_rd_q <= edg_mem[edg_ra];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          case (hdr_i.op)
            CMD_START:  state_d = (arg_a_i != '0) ? S_CLR : S_IDLE;
            CMD_EDGE:   state_d = valid_q ? S_FU : S_IDLE;
            CMD_FINISH: begin
              if (judged_q || !valid_q || comp_q != NW'(1) || ecnt_q == '0) begin
                state_d = S_EMIT;
              end else begin
                state_d = S_PRD;
              end
            end
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_CLR:  if (last_clr) state_d = S_IDLE;
      S_FU:   if (par_rd_q == cur_q) state_d = S_FV;
      S_FV: begin
        if (par_rd_q == cur_q) state_d = (cur_q == ru_q) ? S_IDLE : S_DU;
      end
      S_DU:   state_d = S_DV;
      S_DV:   state_d = S_IDLE;
      S_PRD:  state_d = S_PDU;
      S_PDU:  state_d = S_PDV;
      S_PDV:  state_d = S_PCHK;
      S_PCHK: begin
        if (dbig_q && deg_rd_q == CntTwo) state_d = S_PIU;
        else state_d = last_edge ? S_EMIT : S_PRD;
      end
      S_PIU:  state_d = (inn_rd_q == CntTwo) ? S_EMIT : S_PIV;
      S_PIV:  state_d = (inn_rd_q == CntTwo || last_edge) ? S_EMIT : S_PRD;
      S_EMIT: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    cur_d = cur_q; ru_d = ru_q; cu_d = cu_q; cv_d = cv_q;
    idx_d = idx_q; niu_d = niu_q; comp_d = comp_q; ecnt_d = ecnt_q;
    gnum_d = gnum_q; valid_d = valid_q; judged_d = judged_q;
    verdict_d = verdict_q; res_d = res_q; dbig_d = dbig_q;
    pop_ready_o = 1'b0;
    load = 1'b0;
    par_we = 1'b0; par_wa = cur_q; par_wd = ru_q;
    deg_we = 1'b0; deg_wa = cu_q; deg_ra = cu_q;
    deg_wd = (deg_rd_q == CntZero) ? CntOne : CntTwo;
    inn_we = 1'b0; inn_wa = eu; inn_ra = eu;
    inn_wd = (inn_rd_q == CntZero) ? CntOne : ((inn_rd_q == CntOne) ? CntTwo : CntMore);
    edg_we = 1'b0; edg_wa = ecnt_q[IW-1:0]; edg_wd = {cu_q, cv_q};
    edg_re = 1'b0; edg_ra = idx_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          case (hdr_i.op)
            CMD_START: begin
              niu_d = arg_a_i; comp_d = arg_a_i; ecnt_d = '0; idx_d = '0;
              valid_d = 1'b1; judged_d = 1'b0;
            end
            CMD_EDGE: begin
              cu_d = arg_a_i[IW-1:0]; cv_d = arg_b_i; cur_d = arg_a_i[IW-1:0];
            end
            CMD_FINISH: begin
              gnum_d = hdr_i.gnum; idx_d = '0;
              if (!valid_q || comp_q != NW'(1)) begin
                res_d = 1'b0;
              end else if (judged_q) begin
                res_d = verdict_q;
              end else if (ecnt_q == '0) begin
                res_d = 1'b1; judged_d = 1'b1; verdict_d = 1'b1;
              end
            end
            default: valid_d = 1'b0;
          endcase
        end
      end
      // Reset links, degrees and neighbour counts of the open nodes
      S_CLR: begin
        par_we = 1'b1; par_wa = idx_q[IW-1:0]; par_wd = idx_q[IW-1:0];
        deg_we = 1'b1; deg_wa = idx_q[IW-1:0]; deg_wd = CntZero;
        inn_we = 1'b1; inn_wa = idx_q[IW-1:0]; inn_wd = CntZero;
        idx_d = idx_inc;
      end
      // Walk to the root of the first end
      S_FU: begin
        if (par_rd_q == cur_q) begin
          ru_d = cur_q; cur_d = cv_q;
        end else begin
          cur_d = par_rd_q;
        end
      end
      // Walk to the root of the second end, then join or fail
      S_FV: begin
        if (par_rd_q == cur_q) begin
          if (cur_q == ru_q) begin
            valid_d = 1'b0;
          end else begin
            par_we = 1'b1;
            comp_d = comp_q - NW'(1);
            edg_we = 1'b1;
            ecnt_d = ecnt_q + NW'(1);
          end
        end else begin
          cur_d = par_rd_q;
        end
      end
      S_DU: begin
        deg_we = 1'b1; deg_ra = cv_q;
      end
      S_DV: begin
        deg_we = 1'b1; deg_wa = cv_q;
      end
      S_PRD: edg_re = 1'b1;
      S_PDU: deg_ra = eu;
      S_PDV: begin
        dbig_d = (deg_rd_q == CntTwo); deg_ra = ev;
      end
      S_PCHK: begin
        if (!(dbig_q && deg_rd_q == CntTwo)) begin
          idx_d = idx_inc;
          if (last_edge) begin
            res_d = 1'b1; judged_d = 1'b1; verdict_d = 1'b1;
          end
        end
      end
      S_PIU: begin
        inn_we = 1'b1; inn_ra = ev;
        if (inn_rd_q == CntTwo) begin
          res_d = 1'b0; judged_d = 1'b1; verdict_d = 1'b0;
        end
      end
      S_PIV: begin
        inn_we = 1'b1; inn_wa = ev;
        idx_d = idx_inc;
        if (inn_rd_q == CntTwo) begin
          res_d = 1'b0; judged_d = 1'b1; verdict_d = 1'b0;
        end else if (last_edge) begin
          res_d = 1'b1; judged_d = 1'b1; verdict_d = 1'b1;
        end
      end
      S_EMIT: load = slot_free;
      default: ;
    endcase
    // Fetch the link of the node that the walk visits next
    par_ra = cur_d;
  end

  // Hold the result until the receiver takes it
  assign out_valid_d = load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);
  assign result_o.valid          = out_valid_q;
  assign result_o.is_caterpillar = out_res_q;
  assign result_o.graph_number   = out_gnum_q;

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; ru_q <= ru_d; cu_q <= cu_d; cv_q <= cv_d;
    idx_q <= idx_d; gnum_q <= gnum_d; res_q <= res_d; dbig_q <= dbig_d;
    verdict_q <= verdict_d;
    if (load) begin
      out_res_q  <= res_q;
      out_gnum_q <= gnum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      niu_q       <= '0;
      comp_q      <= '0;
      ecnt_q      <= '0;
      valid_q     <= 1'b0;
      judged_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      niu_q       <= niu_d;
      comp_q      <= comp_d;
      ecnt_q      <= ecnt_d;
      valid_q     <= valid_d;
      judged_q    <= judged_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // Every join trades one component for one stored edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NW'(ecnt_q + comp_q) == niu_q))
    else $error("edge count and component count out of step");

  // A result only appears out of the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result loaded outside emit state");

  // The check pass only runs on a connected, valid graph
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRD) |-> (valid_q && comp_q == NW'(1)))
    else $error("check pass on a failed graph");
`endif

endmodule

@@ rtl/caterpillar_tree_check.sv @@
// Top level of the caterpillar tree checker.
// Items arrive on item_i (valid/ready): start opens a graph of node_count
// nodes, edge adds one edge, finish reports; action three is dropped.
// Each finish yields one beat on result_o with the verdict and the number
// of graphs started since reset (zero before the first start).
// A front end range-checks items and queues commands four deep, so items
// are taken while the back end works or a result waits.
// In the back end, a start sweeps the link, degree and neighbour-count
// memories over the open nodes; an edge walks both root chains (one
// parent-memory read per hop), then joins them and updates both degrees,
// or fails the graph when it closes a cycle; an out-of-range edge fails
// the graph, and an edge to a failed graph is dropped; a finish of a tree
// runs the degree check per edge (one port per memory), then waits for the result register.
// Reset empties the queue and the result register and leaves no graph open,
// so edges fail and a finish reports zero until the first start.
// A stalled receiver holds the result; the back end waits for the slot and
// the queue fills before item_i drops ready.
module caterpillar_tree_check #(
  parameter int unsigned MAX_NODES = ctc_pkg::MaxNodesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctc_in_if.sink    item_i,
  ctc_out_if.source result_o
);
  import ctc_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES + 1);
  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned HW = $bits(cmd_hdr_t);
  localparam int unsigned QW = HW + NW + IW;

  logic          push_valid, push_ready, pop_valid, pop_ready;
  cmd_hdr_t      push_hdr, pop_hdr;
  logic [NW-1:0] push_a, pop_a;
  logic [IW-1:0] push_b, pop_b;
  logic [QW-1:0] push_data, pop_data;

  assign push_data = {push_hdr, push_a, push_b};
  assign pop_hdr   = cmd_hdr_t'(pop_data[QW-1:NW+IW]);
  assign pop_a     = pop_data[NW+IW-1:IW];
  assign pop_b     = pop_data[IW-1:0];

  ctc_front #(.MAX_NODES(MAX_NODES), .NW(NW), .IW(IW)) u_front (
    .clk_i, .rst_ni, .item_i,
    .push_valid_o(push_valid), .push_ready_i(push_ready),
    .hdr_o(push_hdr), .arg_a_o(push_a), .arg_b_o(push_b)
  );

  ctc_fifo #(.WIDTH(QW), .DEPTH(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_data_i(push_data),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_data_o(pop_data)
  );

  ctc_back #(.MAX_NODES(MAX_NODES), .NW(NW), .IW(IW)) u_back (
    .clk_i, .rst_ni,
    .pop_valid_i(pop_valid), .pop_ready_o(pop_ready),
    .hdr_i(pop_hdr), .arg_a_i(pop_a), .arg_b_i(pop_b),
    .result_o
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench of the caterpillar tree checker, with its own predictor.
`timescale 1ns / 100ps

module testbench;
  import ctc_pkg::*;

  localparam int unsigned Nodes      = MaxNodesDef;
  localparam int unsigned ItemTarget = 600;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned TailCycles = 2000;
  localparam int unsigned HoldCycles = 400;

  typedef struct {
    act_e       act;
    logic [7:0] cnt;
    logic [7:0] a;
    logic [7:0] b;
    bit         drain;
  } graph_item_t;

  typedef struct {
    logic        is_cat;
    logic [15:0] gnum;
  } verdict_t;

  logic clk;
  logic rst_n;

  ctc_in_if  item_bus ();
  ctc_out_if res_bus ();

  caterpillar_tree_check #(.MAX_NODES(Nodes)) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(res_bus)
  );

  graph_item_t pending_items[$];
  verdict_t    verdicts_due[$];
  int unsigned errors;
  int unsigned accepted;
  int unsigned cycles;
  bit          burst;

  // Mirror of the checker's graph state
  bit          adj [Nodes][Nodes];
  logic [7:0]  deg [Nodes];
  logic [6:0]  link [Nodes];
  logic [15:0] comps;
  bit          alive;
  logic [7:0]  used;
  logic [15:0] graphs_opened;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report(input string what, input int expv, input int gotv);
    $display("mismatch %s: expected %0d, got %0d", what, expv, gotv);
    errors++;
  endtask

  function automatic void wipe_graph();
    for (int i = 0; i < Nodes; i++) begin
      deg[i]  = '0;
      link[i] = 7'(i);
      for (int j = 0; j < Nodes; j++) adj[i][j] = 1'b0;
    end
  endfunction

  function automatic int root_of(int x);
    int r;
    int nx;
    int steps;
    r = x;
    steps = 0;
    while (int'(link[r]) != r && steps < Nodes) begin
      r = link[r];
      steps++;
    end
    steps = 0;
    // Compress the path behind the walk
    while (x != r && steps < Nodes) begin
      nx = link[x];
      link[x] = 7'(r);
      x = nx;
      steps++;
    end
    return r;
  endfunction

  function automatic bit caterpillar_verdict();
    int hubs;
    if (!alive || comps != 16'd1) return 1'b0;
    for (int u = 0; u < used; u++) begin
      if (deg[u] > 8'd1) begin
        hubs = 0;
        for (int v = 0; v < used; v++)
          if (v != u && adj[u][v] && deg[v] > 8'd1) hubs++;
        if (hubs > 2) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Advance the mirror by one accepted beat
  task automatic apply_item(input graph_item_t it);
    int u;
    int v;
    int ru;
    int rv;
    verdict_t vd;
    case (it.act)
      ACT_START: begin
        wipe_graph();
        used  = (it.cnt > Nodes) ? 8'(Nodes) : it.cnt;
        comps = 16'(used);
        alive = 1'b1;
        graphs_opened = graphs_opened + 16'd1;
      end
      ACT_EDGE: begin
        if (it.a < 1 || it.b < 1 || it.a > used || it.b > used) begin
          alive = 1'b0;
        end else begin
          u = it.a - 1;
          v = it.b - 1;
          if (u == v) alive = 1'b0;
          if (adj[u][v]) alive = 1'b0;
          adj[u][v] = 1'b1;
          adj[v][u] = 1'b1;
          if (deg[u] != 8'd255) deg[u]++;
          if (deg[v] != 8'd255) deg[v]++;
          ru = root_of(u);
          rv = root_of(v);
          if (ru != rv) begin
            link[rv] = 7'(ru);
            comps--;
          end else begin
            alive = 1'b0;
          end
        end
      end
      ACT_FINISH: begin
        vd.is_cat = caterpillar_verdict();
        vd.gnum   = graphs_opened;
        verdicts_due.push_back(vd);
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(input act_e act, input int cnt, input int a, input int b,
                           input bit drain = 1'b0);
    graph_item_t it;
    it.act   = act;
    it.cnt   = 8'(cnt);
    it.a     = 8'(a);
    it.b     = 8'(b);
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  // Queue one tree on n nodes, caterpillar-shaped or arbitrary, with optional damage
  task automatic push_tree(input int n, input bit cat_shape, input bit damage,
                           input bit drain);
    int lab [];
    int ea [$];
    int eb [$];
    int spine;
    int j;
    int t;
    lab = new[n + 1];
    for (int i = 1; i <= n; i++) lab[i] = i;
    for (int i = n; i > 1; i--) begin
      j = $urandom_range(1, i);
      t = lab[i]; lab[i] = lab[j]; lab[j] = t;
    end
    spine = $urandom_range(1, n);
    for (int i = 2; i <= n; i++) begin
      if (cat_shape) j = (i <= spine) ? i - 1 : $urandom_range(1, spine);
      else           j = $urandom_range(1, i - 1);
      if ($urandom_range(0, 1)) begin ea.push_back(lab[i]); eb.push_back(lab[j]); end
      else begin ea.push_back(lab[j]); eb.push_back(lab[i]); end
    end
    for (int i = ea.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ea[i]; ea[i] = ea[j]; ea[j] = t;
      t = eb[i]; eb[i] = eb[j]; eb[j] = t;
    end
    if (damage && ea.size() > 0) begin
      case ($urandom_range(0, 3))
        0: begin ea.pop_back(); eb.pop_back(); end
        1: begin ea.push_back(eb[0]); eb.push_back(ea[0]); end
        2: begin ea.push_back($urandom_range(1, n)); eb.push_back($urandom_range(1, n)); end
        default: begin ea.push_back($urandom_range(0, 255)); eb.push_back(1); end
      endcase
    end
    push_item(ACT_START, n, $urandom_range(0, 255), $urandom_range(0, 255), drain);
    foreach (ea[k]) push_item(ACT_EDGE, $urandom_range(0, 255), ea[k], eb[k]);
    push_item(ACT_FINISH, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255));
  endtask

  // Driver: offer queued beats, predict on acceptance
  bit          offering;
  int unsigned gap_left;
  always @(posedge clk) begin
    if (rst_n) begin
      if (item_bus.valid && item_bus.ready) begin
        apply_item(pending_items.pop_front());
        accepted++;
        offering = 1'b0;
        gap_left = pick_gap();
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && verdicts_due.size() != 0)) begin
          item_bus.action      <= pending_items[0].act;
          item_bus.node_count  <= pending_items[0].cnt;
          item_bus.first_node  <= pending_items[0].a;
          item_bus.second_node <= pending_items[0].b;
          offering = 1'b1;
        end
      end
      item_bus.valid <= offering;
    end
  end

  // Monitor: compare each result beat with the oldest prediction
  bit          hold_done;
  int unsigned hold_left;
  always @(posedge clk) begin
    verdict_t vd;
    if (rst_n) begin
      if (res_bus.valid && res_bus.ready) begin
        if (verdicts_due.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          vd = verdicts_due.pop_front();
          if (res_bus.is_caterpillar !== vd.is_cat)
            report("is_caterpillar", vd.is_cat, res_bus.is_caterpillar);
          if (res_bus.graph_number !== vd.gnum)
            report("graph_number", vd.gnum, res_bus.graph_number);
        end
      end
      // Hold off once for a long stretch so the input side backs up
      if (!hold_done && accepted >= 200) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= (pick_gap() == 0);
      end
    end
  end

  // Cycle counter, burst phases and watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles % 300 == 0) burst = ($urandom_range(0, 2) == 0);
    if (cycles > CycleLimit) begin
      $display("caterpillar_tree_check regression: fail");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    errors = 0; accepted = 0; cycles = 0; burst = 1'b0;
    offering = 1'b0; gap_left = 0; hold_done = 1'b0; hold_left = 0;
    item_bus.valid = 1'b0;
    item_bus.action = ACT_NONE;
    item_bus.node_count = '0;
    item_bus.first_node = '0;
    item_bus.second_node = '0;
    res_bus.ready = 1'b0;
    wipe_graph();
    comps = '0; alive = 1'b0; used = '0; graphs_opened = '0;
    rst_n = 1'b0;

    // Directed: no graph open, action three, empty and clamped counts, faults
    push_item(ACT_EDGE, 0, 1, 2);
    push_item(ACT_FINISH, 0, 0, 0);
    push_item(ACT_NONE, 255, 255, 255);
    push_item(ACT_START, 0, 0, 0);
    push_item(ACT_EDGE, 0, 1, 1);
    push_item(ACT_FINISH, 0, 0, 0);
    push_item(ACT_START, 255, 0, 0);
    push_item(ACT_EDGE, 0, 128, 1);
    push_item(ACT_FINISH, 0, 0, 0);
    push_item(ACT_START, 1, 0, 0);
    push_item(ACT_FINISH, 0, 0, 0);
    push_item(ACT_FINISH, 0, 0, 0);
    // Star with spider: hub 1, arms 2-3-4 each extended, not a caterpillar
    push_item(ACT_START, 7, 0, 0, 1'b1);
    push_item(ACT_EDGE, 0, 1, 2);
    push_item(ACT_EDGE, 0, 1, 3);
    push_item(ACT_EDGE, 0, 1, 4);
    push_item(ACT_EDGE, 0, 2, 5);
    push_item(ACT_EDGE, 0, 3, 6);
    push_item(ACT_EDGE, 0, 4, 7);
    push_item(ACT_FINISH, 0, 0, 0);
    // Self-loop, repeated edge, cycle and out-of-range ends
    push_item(ACT_START, 3, 0, 0);
    push_item(ACT_EDGE, 0, 2, 2);
    push_item(ACT_EDGE, 0, 1, 2);
    push_item(ACT_EDGE, 0, 2, 1);
    push_item(ACT_FINISH, 0, 0, 0);
    push_tree(3, 1'b0, 1'b0, 1'b0);
    push_item(ACT_EDGE, 0, 3, 0);
    push_item(ACT_FINISH, 0, 0, 0);

    // Random: mostly well-formed small trees, a few full-size ones, some noise
    while (pending_items.size() < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_item(act_e'($urandom_range(0, 3)), $urandom_range(0, 255),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        n = (r < 11) ? Nodes : $urandom_range(1, 12);
        push_tree(n, $urandom_range(0, 2) != 0, $urandom_range(0, 4) == 0,
                  $urandom_range(0, 30) == 0);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_items.size() == 0 && !offering);
    wait (verdicts_due.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (verdicts_due.size() != 0) report("results outstanding", 0, verdicts_due.size());
    if (errors == 0) begin
      $display("caterpillar_tree_check regression: pass");
    end else begin
      $display("caterpillar_tree_check regression: fail");
    end
    $finish;
  end

endmodule
